[hw/rtl/tpms_pkg.sv]
// Shared widths, codes, reset values and command types of the touch power mode sequencer.
`timescale 1ns / 1ps

package tpms_pkg;

  localparam int COUNT_WIDTH   = 16;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int CFG_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int LED_WIDTH     = 8;
  localparam int MODE_WIDTH    = 2;
  localparam int SCAN_WIDTH    = 2;
  localparam int PROX_WIDTH    = 2;

  // Derived widths.
  localparam int NUM_WIDTH      = SAMPLE_WIDTH + LED_WIDTH;
  localparam int LIQ_WIDTH      = ((SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH) + 2;
  localparam int CMP_WIDTH      = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int DIV_STEPS      = LED_WIDTH;
  localparam int STEP_CNT_WIDTH = $clog2(DIV_STEPS);

  localparam logic [LED_WIDTH-1:0] LED_FULL = '1;

  localparam logic [MODE_WIDTH-1:0] MODE_ACTIVE = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_LOWREF = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_WOT    = 2'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_LIQUID = 2'd3;

  localparam logic [SCAN_WIDTH-1:0] SCAN_ALL   = 2'd0;
  localparam logic [SCAN_WIDTH-1:0] SCAN_LP    = 2'd1;
  localparam logic [SCAN_WIDTH-1:0] SCAN_GUARD = 2'd2;

  localparam logic [PROX_WIDTH-1:0] PROX_NEAR  = 2'd1;
  localparam logic [PROX_WIDTH-1:0] PROX_TOUCH = 2'd3;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LIQ_THR    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACT_IDLE   = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LR_IDLE    = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LIQ_CLEAR  = 2'd3;

  localparam logic [CFG_WIDTH-1:0] LIQ_THR_RST   = 16'd400;
  localparam logic [CFG_WIDTH-1:0] ACT_IDLE_RST  = 16'd640;
  localparam logic [CFG_WIDTH-1:0] LR_IDLE_RST   = 16'd160;
  localparam logic [CFG_WIDTH-1:0] LIQ_CLEAR_RST = 16'd0;

  typedef struct packed {
    logic load;     // capture the input request
    logic update;   // advance mode and idle count, prepare dividend
    logic setup;    // saturation check and divider start
    logic step;     // one quotient bit
    logic publish;  // load the output register
  } tpms_cmd_t;

endpackage

[hw/rtl/tpms_ctrl.sv]
// Controller state machine that sequences one frame through the datapath.
`timescale 1ns / 1ps

module tpms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpms_pkg::tpms_cmd_t cmd_o
);
  import tpms_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]                state_q, state_d;
  logic [STEP_CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  tpms_cmd_t                 cmd;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.update = 1'b1;
        state_d    = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        cnt_d     = STEP_CNT_WIDTH'(DIV_STEPS - 1);
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FIN: begin
        // The previous result must have left the output register first.
        if (!out_valid_q || out_ready_i) begin
          cmd.publish = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_CALC)
    else $error("accepted request did not start the calculation");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && cnt_q == '0 |=> state_q == ST_FIN)
    else $error("divider did not finish after its last step");

  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |=> out_valid_q && state_q == ST_IDLE)
    else $error("published result not presented");

endmodule

[hw/rtl/tpms_dp.sv]
// Datapath: configuration, mode and idle counter update, serial brightness divider, outputs.
`timescale 1ns / 1ps

module tpms_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tpms_pkg::tpms_cmd_t                   cmd_i,
  input  logic                                  cfg_we_i,
  input  logic [tpms_pkg::CFG_IDX_WIDTH-1:0]    cfg_index_i,
  input  logic [tpms_pkg::CFG_WIDTH-1:0]        cfg_wdata_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]     guard_raw_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]     guard_baseline_i,
  input  logic                                  any_widget_active_i,
  input  logic                                  lp_widget_active_i,
  input  logic [tpms_pkg::PROX_WIDTH-1:0]       prox_state_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]     prox_diff_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]     prox_baseline_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]     prox_max_raw_i,
  output logic [tpms_pkg::MODE_WIDTH-1:0]       mode_o,
  output logic [tpms_pkg::SCAN_WIDTH-1:0]       next_scan_o,
  output logic                                  timer_select_o,
  output logic [tpms_pkg::LED_WIDTH-1:0]        green_level_o,
  output logic [tpms_pkg::LED_WIDTH-1:0]        blue_level_o,
  output logic [tpms_pkg::LED_WIDTH-1:0]        red_level_o
);
  import tpms_pkg::*;

  // Configuration.
  logic [CFG_WIDTH-1:0] liq_thr_q, act_idle_q, lr_idle_q, liq_clear_q;

  // Captured request.
  logic [SAMPLE_WIDTH-1:0] raw_q, base_q, pdiff_q, pbase_q, pmax_q;
  logic                    any_q, lp_q;
  logic [PROX_WIDTH-1:0]   pstat_q;

  // Sequencer state.
  logic [MODE_WIDTH-1:0]  mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] idle_q, idle_d, idle_inc;
  logic                   tsel_q, tsel_d;

  // Divider.
  logic [NUM_WIDTH-1:0]    num_q;
  logic [SAMPLE_WIDTH-1:0] den_q;
  logic [SAMPLE_WIDTH:0]   rem_q, rem_shift;
  logic [LED_WIDTH-1:0]    low_q, quo_q;
  logic                    sat_q, rem_ge;

  // Output register.
  logic [MODE_WIDTH-1:0] mode_out_q;
  logic [SCAN_WIDTH-1:0] scan_q, scan_d;
  logic                  tsel_out_q;
  logic [LED_WIDTH-1:0]  green_q, blue_q, red_q, green_d, blue_d, red_d;

  logic [LIQ_WIDTH-1:0] liq_diff;
  logic                 liquid;
  logic                 exceed_act, exceed_lr, exceed_liq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      liq_thr_q   <= LIQ_THR_RST;
      act_idle_q  <= ACT_IDLE_RST;
      lr_idle_q   <= LR_IDLE_RST;
      liq_clear_q <= LIQ_CLEAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LIQ_THR:   liq_thr_q   <= cfg_wdata_i;
        CFG_ACT_IDLE:  act_idle_q  <= cfg_wdata_i;
        CFG_LR_IDLE:   lr_idle_q   <= cfg_wdata_i;
        CFG_LIQ_CLEAR: liq_clear_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q   <= guard_raw_i;
      base_q  <= guard_baseline_i;
      any_q   <= any_widget_active_i;
      lp_q    <= lp_widget_active_i;
      pstat_q <= prox_state_i;
      pdiff_q <= prox_diff_i;
      pbase_q <= prox_baseline_i;
      pmax_q  <= prox_max_raw_i;
    end
  end

  // Guard difference is signed; the threshold is never negative.
  assign liq_diff = LIQ_WIDTH'(base_q) - LIQ_WIDTH'(raw_q);
  assign liquid   = $signed(liq_diff) >= $signed(LIQ_WIDTH'(liq_thr_q));

  // The idle count saturates, so a limit at its maximum is never exceeded.
  assign idle_inc   = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign exceed_act = CMP_WIDTH'(idle_inc) > CMP_WIDTH'(act_idle_q);
  assign exceed_lr  = CMP_WIDTH'(idle_inc) > CMP_WIDTH'(lr_idle_q);
  assign exceed_liq = CMP_WIDTH'(idle_inc) > CMP_WIDTH'(liq_clear_q);

  always_comb begin
    mode_d = mode_q;
    idle_d = idle_q;
    tsel_d = tsel_q;
    unique case (mode_q)
      MODE_ACTIVE: begin
        if (liquid) begin
          mode_d = MODE_LIQUID;
          idle_d = '0;
        end else if (any_q) begin
          idle_d = '0;
        end else if (exceed_act) begin
          mode_d = MODE_LOWREF;
          idle_d = '0;
          tsel_d = 1'b1;
        end else begin
          idle_d = idle_inc;
        end
      end
      MODE_LOWREF: begin
        if (liquid) begin
          mode_d = MODE_LIQUID;
          idle_d = '0;
        end else if (any_q) begin
          mode_d = MODE_ACTIVE;
          idle_d = '0;
          tsel_d = 1'b0;
        end else if (exceed_lr) begin
          mode_d = MODE_WOT;
          idle_d = '0;
        end else begin
          idle_d = idle_inc;
        end
      end
      MODE_WOT: begin
        idle_d = '0;
        mode_d = lp_q ? MODE_ACTIVE : MODE_LOWREF;
        tsel_d = !lp_q;
      end
      default: begin
        if (liquid) begin
          idle_d = '0;
        end else if (exceed_liq) begin
          mode_d = MODE_ACTIVE;
          idle_d = '0;
        end else begin
          idle_d = idle_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ACTIVE;
      idle_q <= '0;
      tsel_q <= 1'b0;
    end else if (cmd_i.update) begin
      mode_q <= mode_d;
      idle_q <= idle_d;
      tsel_q <= tsel_d;
    end
  end

  // Restoring division of diff*255 by the wrapped span, one quotient bit per step.
  // A quotient of 256 or more, a zero divisor included, saturates.
  assign rem_shift = {rem_q[SAMPLE_WIDTH-1:0], low_q[LED_WIDTH-1]};
  assign rem_ge    = rem_shift >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      num_q <= (NUM_WIDTH'(pdiff_q) << LED_WIDTH) - NUM_WIDTH'(pdiff_q);
      den_q <= pmax_q - pbase_q;
    end
    if (cmd_i.setup) begin
      sat_q <= num_q >= {den_q, LED_WIDTH'(0)};
      rem_q <= {1'b0, num_q[NUM_WIDTH-1:LED_WIDTH]};
      low_q <= num_q[LED_WIDTH-1:0];
      quo_q <= '0;
    end
    if (cmd_i.step) begin
      rem_q <= rem_ge ? rem_shift - {1'b0, den_q} : rem_shift;
      low_q <= {low_q[LED_WIDTH-2:0], 1'b0};
      quo_q <= {quo_q[LED_WIDTH-2:0], rem_ge};
    end
  end

  always_comb begin
    green_d = '0;
    blue_d  = '0;
    red_d   = '0;
    if (mode_q == MODE_LIQUID) begin
      red_d = LED_FULL;
    end else if (pstat_q == PROX_NEAR) begin
      green_d = sat_q ? LED_FULL : quo_q;
    end else if (pstat_q == PROX_TOUCH) begin
      green_d = LED_FULL;
      blue_d  = LED_FULL;
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_WOT:    scan_d = SCAN_LP;
      MODE_LIQUID: scan_d = SCAN_GUARD;
      default:     scan_d = SCAN_ALL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      mode_out_q <= mode_q;
      scan_q     <= scan_d;
      tsel_out_q <= tsel_q;
      green_q    <= green_d;
      blue_q     <= blue_d;
      red_q      <= red_d;
    end
  end

  assign mode_o         = mode_out_q;
  assign next_scan_o    = scan_q;
  assign timer_select_o = tsel_out_q;
  assign green_level_o  = green_q;
  assign blue_level_o   = blue_q;
  assign red_level_o    = red_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.setup && !(num_q >= {den_q, LED_WIDTH'(0)})) || (cmd_i.step && !sat_q)
    |=> rem_q < {1'b0, den_q})
    else $error("divider remainder not below divisor");

  a_liquid_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish && mode_q == MODE_LIQUID
    |=> red_q == LED_FULL && green_q == '0 && scan_q == SCAN_GUARD)
    else $error("liquid mode outputs wrong");

  a_wot_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && mode_q == MODE_WOT |=> idle_q == '0 && mode_q != MODE_WOT)
    else $error("wake-on-touch did not hand over");

endmodule

[hw/rtl/touch_power_mode_sequencer.sv]
// Top level of the touch power mode sequencer: controller plus datapath.
`timescale 1ns / 1ps
// Steps per request: mode update, divider setup, the serial quotient steps, then a publish
// step that waits until the previous result has left the output register.
// The bit-serial divider keeps the block busy; a new request is taken only after publish.
// A new request is taken while the previous result still waits in the output register.
// Reset (async, active low): active mode, idle count zero, active timer rate, registers
// at their defaults; no result pending.

module touch_power_mode_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tpms_pkg::CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [tpms_pkg::CFG_WIDTH-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]  guard_raw_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]  guard_baseline_i,
  input  logic                               any_widget_active_i,
  input  logic                               lp_widget_active_i,
  input  logic [tpms_pkg::PROX_WIDTH-1:0]    prox_state_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]  prox_diff_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]  prox_baseline_i,
  input  logic [tpms_pkg::SAMPLE_WIDTH-1:0]  prox_max_raw_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tpms_pkg::MODE_WIDTH-1:0]    mode_o,
  output logic [tpms_pkg::SCAN_WIDTH-1:0]    next_scan_o,
  output logic                               timer_select_o,
  output logic [tpms_pkg::LED_WIDTH-1:0]     green_level_o,
  output logic [tpms_pkg::LED_WIDTH-1:0]     blue_level_o,
  output logic [tpms_pkg::LED_WIDTH-1:0]     red_level_o
);
  import tpms_pkg::*;

  tpms_cmd_t cmd;

  tpms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tpms_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .guard_raw_i         (guard_raw_i),
    .guard_baseline_i    (guard_baseline_i),
    .any_widget_active_i (any_widget_active_i),
    .lp_widget_active_i  (lp_widget_active_i),
    .prox_state_i        (prox_state_i),
    .prox_diff_i         (prox_diff_i),
    .prox_baseline_i     (prox_baseline_i),
    .prox_max_raw_i      (prox_max_raw_i),
    .mode_o              (mode_o),
    .next_scan_o         (next_scan_o),
    .timer_select_o      (timer_select_o),
    .green_level_o       (green_level_o),
    .blue_level_o        (blue_level_o),
    .red_level_o         (red_level_o)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the touch power mode sequencer.
`timescale 1ns / 1ps

module tb;
  import tpms_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int PHASE_FRAMES     = 165;
  localparam int LONG_HOLD_AT     = 450;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] guard_raw;
    logic [SAMPLE_WIDTH-1:0] guard_baseline;
    logic                    any_active;
    logic                    lp_active;
    logic [PROX_WIDTH-1:0]   prox_state;
    logic [SAMPLE_WIDTH-1:0] prox_diff;
    logic [SAMPLE_WIDTH-1:0] prox_baseline;
    logic [SAMPLE_WIDTH-1:0] prox_max_raw;
  } frame_t;

  typedef struct packed {
    logic [MODE_WIDTH-1:0] mode;
    logic [SCAN_WIDTH-1:0] next_scan;
    logic                  timer_sel;
    logic [LED_WIDTH-1:0]  green;
    logic [LED_WIDTH-1:0]  blue;
    logic [LED_WIDTH-1:0]  red;
  } mode_update_t;

  // Tracks the sequencer state and holds the mode updates still owed by the block.
  class mode_tracker;
    logic [CFG_WIDTH-1:0]   liq_thr;
    logic [CFG_WIDTH-1:0]   act_limit;
    logic [CFG_WIDTH-1:0]   lr_limit;
    logic [CFG_WIDTH-1:0]   clear_limit;
    logic [MODE_WIDTH-1:0]  mode;
    logic [COUNT_WIDTH-1:0] idle_cnt;
    logic                   timer_sel;
    mode_update_t           awaited[$];
    int                     mismatches;

    function new();
      liq_thr     = LIQ_THR_RST;
      act_limit   = ACT_IDLE_RST;
      lr_limit    = LR_IDLE_RST;
      clear_limit = LIQ_CLEAR_RST;
      mode        = MODE_ACTIVE;
      idle_cnt    = '0;
      timer_sel   = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
      case (idx)
        CFG_LIQ_THR:   liq_thr = val;
        CFG_ACT_IDLE:  act_limit = val;
        CFG_LR_IDLE:   lr_limit = val;
        CFG_LIQ_CLEAR: clear_limit = val;
        default: ;
      endcase
    endfunction

    // The idle count sticks at its maximum instead of wrapping.
    function bit idle_expired(logic [CFG_WIDTH-1:0] limit);
      if (idle_cnt != '1) idle_cnt = idle_cnt + 1'b1;
      return idle_cnt > limit;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void take_frame(frame_t f);
      mode_update_t         u;
      logic                 liquid;
      logic [SAMPLE_WIDTH-1:0] den;
      logic [NUM_WIDTH-1:0] quot;
      liquid = (int'(f.guard_baseline) - int'(f.guard_raw)) >= int'(liq_thr);
      case (mode)
        MODE_ACTIVE: begin
          if (liquid) begin
            mode = MODE_LIQUID;
            idle_cnt = '0;
          end else if (f.any_active) begin
            idle_cnt = '0;
          end else if (idle_expired(act_limit)) begin
            mode = MODE_LOWREF;
            idle_cnt = '0;
            timer_sel = 1'b1;
          end
        end
        MODE_LOWREF: begin
          if (liquid) begin
            mode = MODE_LIQUID;
            idle_cnt = '0;
          end else if (f.any_active) begin
            mode = MODE_ACTIVE;
            idle_cnt = '0;
            timer_sel = 1'b0;
          end else if (idle_expired(lr_limit)) begin
            mode = MODE_WOT;
            idle_cnt = '0;
          end
        end
        MODE_WOT: begin
          idle_cnt = '0;
          mode = f.lp_active ? MODE_ACTIVE : MODE_LOWREF;
          timer_sel = !f.lp_active;
        end
        default: begin
          if (liquid) begin
            idle_cnt = '0;
          end else if (idle_expired(clear_limit)) begin
            mode = MODE_ACTIVE;
            idle_cnt = '0;
          end
        end
      endcase

      u = '0;
      u.mode = mode;
      u.timer_sel = timer_sel;
      if (mode == MODE_LIQUID) begin
        u.red = LED_FULL;
      end else if (f.prox_state == PROX_NEAR) begin
        den = f.prox_max_raw - f.prox_baseline;
        if (den == '0) begin
          u.green = LED_FULL;
        end else begin
          quot = (NUM_WIDTH'(f.prox_diff) * NUM_WIDTH'(255)) / NUM_WIDTH'(den);
          u.green = (quot > NUM_WIDTH'(LED_FULL)) ? LED_FULL : quot[LED_WIDTH-1:0];
        end
      end else if (f.prox_state == PROX_TOUCH) begin
        u.green = LED_FULL;
        u.blue = LED_FULL;
      end
      if (mode == MODE_WOT) u.next_scan = SCAN_LP;
      else if (mode == MODE_LIQUID) u.next_scan = SCAN_GUARD;
      else u.next_scan = SCAN_ALL;
      awaited.push_back(u);
    endfunction

    function void check_field(string name, int want, int seen);
      if (want != seen) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      end
    endfunction

    function void check_update(mode_update_t got);
      mode_update_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got mode %0d", $time, got.mode);
        return;
      end
      want = awaited.pop_front();
      check_field("mode", want.mode, got.mode);
      check_field("next_scan", want.next_scan, got.next_scan);
      check_field("timer_select", want.timer_sel, got.timer_sel);
      check_field("green_level", want.green, got.green);
      check_field("blue_level", want.blue, got.blue);
      check_field("red_level", want.red, got.red);
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index_i = CFG_LIQ_THR;
  logic [CFG_WIDTH-1:0]     cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [SAMPLE_WIDTH-1:0]  guard_raw_i = '0;
  logic [SAMPLE_WIDTH-1:0]  guard_baseline_i = '0;
  logic                     any_widget_active_i = 1'b0;
  logic                     lp_widget_active_i = 1'b0;
  logic [PROX_WIDTH-1:0]    prox_state_i = '0;
  logic [SAMPLE_WIDTH-1:0]  prox_diff_i = '0;
  logic [SAMPLE_WIDTH-1:0]  prox_baseline_i = '0;
  logic [SAMPLE_WIDTH-1:0]  prox_max_raw_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [MODE_WIDTH-1:0]    mode_o;
  logic [SCAN_WIDTH-1:0]    next_scan_o;
  logic                     timer_select_o;
  logic [LED_WIDTH-1:0]     green_level_o;
  logic [LED_WIDTH-1:0]     blue_level_o;
  logic [LED_WIDTH-1:0]     red_level_o;

  mode_tracker  tracker;
  mode_update_t seen_update;
  frame_t       script[$];
  int           frames_sent = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           liq_thr_now = 0;
  int           hold_left = 0;
  bit           long_hold_done = 1'b0;
  int           cycles = 0;

  touch_power_mode_sequencer dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .guard_raw_i         (guard_raw_i),
    .guard_baseline_i    (guard_baseline_i),
    .any_widget_active_i (any_widget_active_i),
    .lp_widget_active_i  (lp_widget_active_i),
    .prox_state_i        (prox_state_i),
    .prox_diff_i         (prox_diff_i),
    .prox_baseline_i     (prox_baseline_i),
    .prox_max_raw_i      (prox_max_raw_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .mode_o              (mode_o),
    .next_scan_o         (next_scan_o),
    .timer_select_o      (timer_select_o),
    .green_level_o       (green_level_o),
    .blue_level_o        (blue_level_o),
    .red_level_o         (red_level_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("touch_power_mode_sequencer test failed");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold-off so the block fills up.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && frames_sent >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_update.mode      = mode_o;
      seen_update.next_scan = next_scan_o;
      seen_update.timer_sel = timer_select_o;
      seen_update.green     = green_level_o;
      seen_update.blue      = blue_level_o;
      seen_update.red       = red_level_o;
      tracker.check_update(seen_update);
    end
  end

  function automatic frame_t frame_of(int raw, int base, int any, int lp, int stat,
                                      int diff, int pbase, int pmax);
    frame_t f;
    f.guard_raw      = SAMPLE_WIDTH'(raw);
    f.guard_baseline = SAMPLE_WIDTH'(base);
    f.any_active     = 1'(any);
    f.lp_active      = 1'(lp);
    f.prox_state     = PROX_WIDTH'(stat);
    f.prox_diff      = SAMPLE_WIDTH'(diff);
    f.prox_baseline  = SAMPLE_WIDTH'(pbase);
    f.prox_max_raw   = SAMPLE_WIDTH'(pmax);
    return f;
  endfunction

  // Guard readings cluster around the liquid threshold; proximity data is mostly sane
  // with a share of fully random values that covers wrapped divisors and every bit.
  function automatic frame_t random_frame(int thr);
    int pick, raw, base, d, span, diff, pbase, pmax;
    pick = $urandom_range(99);
    base = $urandom_range(65535);
    if (pick < 10) begin
      raw = $urandom_range(65535);
    end else begin
      if (pick < 30) d = thr + $urandom_range(20);
      else d = thr - 1 - $urandom_range(150);
      raw = base - d;
      if (raw < 0) raw = 0;
      if (raw > 65535) raw = 65535;
    end
    pick = $urandom_range(99);
    if (pick < 30) begin
      diff  = $urandom_range(65535);
      pbase = $urandom_range(65535);
      pmax  = $urandom_range(65535);
    end else begin
      pbase = $urandom_range(40000);
      span  = (pick < 36) ? 0 : $urandom_range(25000, 1);
      pmax  = pbase + span;
      diff  = $urandom_range(span + span / 4);
    end
    return frame_of(raw, base, ($urandom_range(99) < 25) ? 1 : 0, $urandom_range(1),
                    $urandom_range(3), diff, pbase, pmax);
  endfunction

  task automatic load_settings(input int thr, input int act, input int lr, input int clr);
    logic [CFG_IDX_WIDTH-1:0] idx[4];
    int                       vals[4];
    idx  = '{CFG_LIQ_THR, CFG_ACT_IDLE, CFG_LR_IDLE, CFG_LIQ_CLEAR};
    vals = '{thr, act, lr, clr};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= CFG_WIDTH'(vals[i]);
      @(posedge clk_i);
      tracker.set_reg(idx[i], CFG_WIDTH'(vals[i]));
    end
    cfg_we_i <= 1'b0;
    liq_thr_now = thr;
  endtask

  task automatic send_frame(input frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    guard_raw_i         <= f.guard_raw;
    guard_baseline_i    <= f.guard_baseline;
    any_widget_active_i <= f.any_active;
    lp_widget_active_i  <= f.lp_active;
    prox_state_i        <= f.prox_state;
    prox_diff_i         <= f.prox_diff;
    prox_baseline_i     <= f.prox_baseline;
    prox_max_raw_i      <= f.prox_max_raw;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_frame(f);
    frames_sent <= frames_sent + 1;
  endtask

  // Stop offering requests until every owed result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct <= 71;
    load_settings(400, 1, 0, 0);

    // Proximity brightness cases first, kept in active mode by widget activity.
    script.push_back(frame_of(0, 0, 0, 0, 0, 0, 0, 0));
    script.push_back(frame_of(500, 300, 1, 0, PROX_NEAR, 100, 100, 1100));
    script.push_back(frame_of(900, 600, 1, 0, PROX_NEAR, 500, 7, 7));
    script.push_back(frame_of(65535, 0, 1, 1, PROX_NEAR, 65535, 65535, 1));
    script.push_back(frame_of(1000, 1399, 1, 0, PROX_NEAR, 2000, 0, 1000));
    script.push_back(frame_of(0, 399, 1, 0, 2, 65535, 0, 65535));
    script.push_back(frame_of(12, 12, 1, 0, PROX_TOUCH, 40, 10, 90));
    // Liquid entry, a held liquid frame, then clearing back to active.
    script.push_back(frame_of(0, 65535, 1, 1, PROX_NEAR, 300, 0, 600));
    script.push_back(frame_of(1000, 1400, 0, 0, PROX_TOUCH, 0, 0, 0));
    script.push_back(frame_of(1000, 1399, 0, 0, 0, 0, 0, 0));
    // Idle frames into low refresh, liquid from there, and back.
    script.push_back(frame_of(65535, 0, 0, 0, 0, 0, 0, 0));
    script.push_back(frame_of(2000, 2000, 0, 1, 0, 0, 0, 0));
    script.push_back(frame_of(100, 30000, 1, 0, PROX_NEAR, 10, 5, 15));
    script.push_back(frame_of(100, 100, 0, 0, 0, 0, 0, 0));
    script.push_back(frame_of(100, 100, 0, 0, 0, 0, 0, 0));
    script.push_back(frame_of(100, 100, 0, 0, PROX_TOUCH, 0, 0, 0));
    script.push_back(frame_of(100, 100, 1, 0, 0, 0, 0, 0));
    // Low refresh into wake-on-touch, out without and then with a touch.
    script.push_back(frame_of(100, 100, 0, 0, 0, 0, 0, 0));
    script.push_back(frame_of(100, 100, 0, 0, 0, 0, 0, 0));
    script.push_back(frame_of(100, 100, 0, 1, PROX_NEAR, 255, 0, 255));
    script.push_back(frame_of(100, 100, 0, 0, 0, 0, 0, 0));
    script.push_back(frame_of(100, 100, 0, 0, 0, 0, 0, 0));
    script.push_back(frame_of(100, 100, 0, 1, PROX_TOUCH, 0, 0, 0));
    foreach (script[i]) send_frame(script[i]);

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (phase)
        0: load_settings(65535, 0, 0, 65534);
        1: begin
          send_idle_pct = 71;
          recv_idle_pct <= 16;
          load_settings(0, 65534, 65534, 0);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
          load_settings($urandom_range(2000, 50), $urandom_range(6), $urandom_range(6),
                        $urandom_range(4));
        end
      endcase
      for (int k = 0; k < PHASE_FRAMES; k++) begin
        if (phase == 2 && k == 60) drain();
        send_frame(random_frame(liq_thr_now));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("touch_power_mode_sequencer test passed");
    end else begin
      $display("touch_power_mode_sequencer test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tpms_pkg.sv
hw/rtl/tpms_ctrl.sv
hw/rtl/tpms_dp.sv
hw/rtl/touch_power_mode_sequencer.sv
tb/sv/tb.sv
